// ----- design/dnrc_pkg.sv -----
// ----------------------------------------------------------------------------
// dnrc_pkg
// Shared widths, stage counts and constants of the radiometric calibration
// pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dnrc_pkg;

	// datapath widths
	localparam int RAD_W  = 40;  // magnitude of a positive radiance
	localparam int RADS_W = 41;  // signed radiance gain*dn+bias
	localparam int Q1_W   = 62;  // k_one*2^30 / radiance
	localparam int X_W    = 63;  // quotient plus one in Q.30
	localparam int E_W    = 6;   // integer part of log2
	localparam int FRAC_W = 30;  // fraction of log2
	localparam int L2_W   = E_W + FRAC_W;
	localparam int LN_W   = 35;  // natural log in Q.30
	localparam int Q2_W   = 31;  // kelvin quotient below saturation

	// stage counts
	localparam int DIV1_STEPS  = 62;
	localparam int NORM_STEPS  = 6;
	localparam int SQ_STEPS    = FRAC_W;
	localparam int LN_STAGES   = 2;
	localparam int DIV2_STEPS  = Q2_W;
	localparam int TEMP_DEPTH  = DIV1_STEPS + NORM_STEPS + SQ_STEPS + LN_STAGES + DIV2_STEPS;
	localparam int REFL_STAGES = 5;
	localparam int ALIGN_DEPTH = TEMP_DEPTH - REFL_STAGES;
	localparam int PIPE_END    = TEMP_DEPTH + 1;
	// sampling edges from the accepting edge to the edge that sees done
	localparam int OUT_LAT     = PIPE_END + 1;

	// constants
	localparam logic [26:0]    LN2_Q27     = 27'd93032639;
	localparam logic [X_W-1:0] ONE_Q30     = X_W'(64'h4000_0000);
	localparam logic [31:0]    NEG_HUNDRED = 32'hFF9C_0000;
	localparam logic [31:0]    NEG_ONE     = 32'hFFFF_0000;
	localparam logic [31:0]    REFL_BAD    = 32'd32767;
	localparam logic [31:0]    INT_MAX     = 32'h7FFF_FFFF;
	localparam logic [31:0]    INT_MIN     = 32'h8000_0000;
	localparam logic [13:0]    SCALE_10K   = 14'd10000;

	// register reset values
	localparam logic [30:0] GAIN_RST = 31'd65536;
	localparam logic [31:0] BIAS_RST = 32'd0;
	localparam logic [31:0] RFAC_RST = 32'd1073741824;
	localparam logic [31:0] KONE_RST = 32'd65536;
	localparam logic [31:0] KTWO_RST = 32'd65536;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_RAD  = 2'd1,
		MODE_REFL = 2'd2,
		MODE_TEMP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_GAIN = 3'd1,
		REG_BIAS = 3'd2,
		REG_RFAC = 3'd3,
		REG_KONE = 3'd4,
		REG_KTWO = 3'd5
	} reg_idx_t;

endpackage

// ----- design/dn_radiometric_calibration.sv -----
// ----------------------------------------------------------------------------
// dn_radiometric_calibration
// Converts 8-bit pixel counts to raw, radiance, reflectance or brightness
// temperature, one word per clock.
// ----------------------------------------------------------------------------
// done rises when the accepted word leaves the valid pipeline and the output register
// throughput: one word per cycle in every mode, busy is never raised
// latency is set by the temperature path: two bit-per-stage dividers and
// thirty squaring stages for the log; other modes are delayed to match
// reset clears the valid pipeline and loads the register defaults
`timescale 1ns / 1ps

module dn_radiometric_calibration import dnrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  dn,
	input  logic        last_pixel,
	output logic        done,
	output logic [31:0] value,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef struct packed {
		logic        last;
		logic        fill;
		logic        neg;
		logic        pos;
		logic [7:0]  dn;
		logic [31:0] radv;
	} early_t;

	typedef struct packed {
		logic        last;
		logic        use_temp;
		logic [31:0] val;
	} side_t;

	// configuration registers
	mode_t       mode_q;
	logic [30:0] gain_q;
	logic [31:0] bias_q;
	logic [31:0] rfac_q;
	logic [31:0] kone_q;
	logic [31:0] ktwo_q;
	reg_idx_t    idx;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
			gain_q <= GAIN_RST;
			bias_q <= BIAS_RST;
			rfac_q <= RFAC_RST;
			kone_q <= KONE_RST;
			ktwo_q <= KTWO_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MODE: mode_q <= mode_t'(pwdata[1:0]);
				REG_GAIN: gain_q <= pwdata[30:0];
				REG_BIAS: bias_q <= pwdata;
				REG_RFAC: rfac_q <= pwdata;
				REG_KONE: kone_q <= pwdata;
				REG_KTWO: ktwo_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE: prdata = {30'd0, mode_q};
			REG_GAIN: prdata = {1'b0, gain_q};
			REG_BIAS: prdata = bias_q;
			REG_RFAC: prdata = rfac_q;
			REG_KONE: prdata = kone_q;
			REG_KTWO: prdata = ktwo_q;
			default:  prdata = '0;
		endcase
	end

	// valid bits for every stage up to the alignment point
	logic [PIPE_END:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PIPE_END-1:1], start && !busy};
		end
	end

	// stage 1: radiance
	logic signed [RADS_W-1:0] rad_s1;
	logic [7:0]               dn_s1;
	logic                     last_s1;
	logic [38:0]              prod;

	assign prod = 39'(gain_q) * 39'(dn);

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			rad_s1  <= $signed({2'b00, prod}) + $signed({{9{bias_q[31]}}, bias_q});
			dn_s1   <= dn;
			last_s1 <= last_pixel;
		end
	end

	// stage 2: magnitude and saturated radiance
	early_t      e_s2, e_s3, e_s4, e_s5;
	logic [39:0] mag_s2;
	logic [31:0] radv;

	always_comb begin
		if (rad_s1 > $signed(41'h000_7FFF_FFFF)) begin
			radv = INT_MAX;
		end else if (rad_s1 < $signed(41'h1FF_8000_0000)) begin
			radv = INT_MIN;
		end else begin
			radv = rad_s1[31:0];
		end
	end

	always_ff @(posedge clk) begin
		e_s2.last <= last_s1;
		e_s2.fill <= dn_s1 == 8'd0;
		e_s2.neg  <= rad_s1[RADS_W-1];
		e_s2.pos  <= !rad_s1[RADS_W-1] && rad_s1 != '0;
		e_s2.dn   <= dn_s1;
		e_s2.radv <= radv;
		mag_s2    <= rad_s1[RADS_W-1] ? 40'(-rad_s1) : rad_s1[39:0];
	end

	// stages 3 to 6: reflectance
	logic [55:0] a_s3, b_s3;
	logic [56:0] qq_s4;
	logic [15:0] r_s4;
	logic        big_s5;
	logic [47:0] p1_s5;
	logic [13:0] p2_s5;
	logic [29:0] rr;

	assign rr = 30'(r_s4) * 30'(SCALE_10K);

	always_ff @(posedge clk) begin
		e_s3   <= e_s2;
		a_s3   <= 56'(mag_s2) * 56'(rfac_q[31:16]);
		b_s3   <= 56'(mag_s2) * 56'(rfac_q[15:0]);
		e_s4   <= e_s3;
		qq_s4  <= 57'(a_s3) + 57'(b_s3[55:16]);
		r_s4   <= b_s3[15:0];
		e_s5   <= e_s4;
		big_s5 <= qq_s4[56:34] != '0;
		p1_s5  <= 48'(qq_s4[33:0]) * 48'(SCALE_10K);
		p2_s5  <= rr[29:16];
	end

	logic [48:0] rsum;
	logic [18:0] rmag;
	logic [15:0] refl;
	side_t       o_s6;
	side_t       side_d;

	assign rsum = 49'(p1_s5) + 49'(p2_s5);
	assign rmag = big_s5 ? 19'd32768 : rsum[48:30];

	always_comb begin
		if (!e_s5.neg) begin
			refl = (rmag > 19'd32767) ? 16'h7FFF : rmag[15:0];
		end else begin
			refl = (rmag > 19'd32768) ? 16'h8000 : 16'(-rmag[15:0]);
		end
	end

	always_comb begin
		side_d.last     = e_s5.last;
		side_d.use_temp = 1'b0;
		unique case (mode_q)
			MODE_RAW:  side_d.val = {24'd0, e_s5.dn};
			MODE_RAD:  side_d.val = e_s5.fill ? NEG_HUNDRED : e_s5.radv;
			MODE_REFL: side_d.val = e_s5.fill ? REFL_BAD : {{16{refl[15]}}, refl};
			MODE_TEMP: begin
				side_d.val      = NEG_ONE;
				side_d.use_temp = !e_s5.fill && e_s5.pos;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		o_s6 <= side_d;
	end

	// delay line matching the temperature path
	side_t algn_s [0:ALIGN_DEPTH-1];

	always_ff @(posedge clk) begin
		algn_s[0] <= o_s6;
		for (int i = 1; i < ALIGN_DEPTH; i++) begin
			algn_s[i] <= algn_s[i-1];
		end
	end

	// temperature path
	logic [Q1_W-1:0] quo;
	logic [LN_W-1:0] ln_w;

	dnrc_quot u_quot (
		.clk   (clk),
		.den   (rad_s1[RAD_W-1:0]),
		.k_one (kone_q),
		.quo   (quo)
	);

	dnrc_log u_log (
		.clk (clk),
		.quo (quo),
		.ln  (ln_w)
	);

	// k_two*2^30 / ln; saturation known up front when k_two >= 2*ln
	logic [LN_W-1:0] d2_rem_s [1:DIV2_STEPS];
	logic [LN_W-1:0] d2_ln_s  [1:DIV2_STEPS];
	logic [Q2_W-1:0] d2_quo_s [1:DIV2_STEPS];
	logic            d2_sat_s [1:DIV2_STEPS];

	for (genvar g = 1; g <= DIV2_STEPS; g++) begin : g_div2
		logic [LN_W-1:0] rem_prev;
		logic [LN_W-1:0] ln_prev;
		logic [Q2_W-1:0] quo_prev;
		logic            sat_prev;
		logic            nbit;
		logic [LN_W:0]   trial;
		logic            ge;

		if (g == 1) begin : g_first
			assign rem_prev = LN_W'(ktwo_q[31:1]);
			assign ln_prev  = ln_w;
			assign quo_prev = '0;
			assign sat_prev = {4'd0, ktwo_q} >= {ln_w, 1'b0};
			assign nbit     = ktwo_q[0];
		end else begin : g_next
			assign rem_prev = d2_rem_s[g-1];
			assign ln_prev  = d2_ln_s[g-1];
			assign quo_prev = d2_quo_s[g-1];
			assign sat_prev = d2_sat_s[g-1];
			assign nbit     = 1'b0;
		end

		assign trial = {rem_prev, nbit};
		assign ge    = trial >= {1'b0, ln_prev};

		always_ff @(posedge clk) begin
			d2_rem_s[g] <= ge ? LN_W'(trial - {1'b0, ln_prev}) : trial[LN_W-1:0];
			d2_ln_s[g]  <= ln_prev;
			d2_quo_s[g] <= {quo_prev[Q2_W-2:0], ge};
			d2_sat_s[g] <= sat_prev;
		end
	end

	logic [31:0] temp_val;

	assign temp_val = d2_sat_s[DIV2_STEPS] ? INT_MAX : {1'b0, d2_quo_s[DIV2_STEPS]};

	// output word
	logic        done_q;
	logic [31:0] value_q;
	logic        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[PIPE_END];
		end
	end

	always_ff @(posedge clk) begin
		value_q <= algn_s[ALIGN_DEPTH-1].use_temp ? temp_val : algn_s[ALIGN_DEPTH-1].val;
		last_q  <= algn_s[ALIGN_DEPTH-1].last;
	end

	assign done  = done_q;
	assign value = value_q;
	assign last  = last_q;

`ifndef ASSERT_OFF
	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("result word without an accepted input word");

	a_word_enters: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> vld_s[1])
		else $error("accepted word lost at pipeline entry");

	a_temp_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[PIPE_END] && algn_s[ALIGN_DEPTH-1].use_temp |=> done && !value[31])
		else $error("temperature path gave a negative value");
`endif

endmodule

// ----- design/dnrc_quot.sv -----
// ----------------------------------------------------------------------------
// dnrc_quot
// Pipelined restoring divider, k_one*2^30 / radiance, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnrc_quot import dnrc_pkg::*; (
	input  logic             clk,
	input  logic [RAD_W-1:0] den,
	input  logic [31:0]      k_one,
	output logic [Q1_W-1:0]  quo
);

	logic [RAD_W-1:0] rem_s [1:DIV1_STEPS];
	logic [RAD_W-1:0] den_s [1:DIV1_STEPS];
	logic [Q1_W-1:0]  quo_s [1:DIV1_STEPS];

	for (genvar g = 1; g <= DIV1_STEPS; g++) begin : g_step
		logic [RAD_W-1:0] rem_prev;
		logic [RAD_W-1:0] den_prev;
		logic [Q1_W-1:0]  quo_prev;
		logic             nbit;
		logic [RAD_W:0]   trial;
		logic             ge;

		if (g == 1) begin : g_first
			assign rem_prev = '0;
			assign den_prev = den;
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[g-1];
			assign den_prev = den_s[g-1];
			assign quo_prev = quo_s[g-1];
		end

		// numerator bits come from k_one, the low thirty are zero
		if (g <= 32) begin : g_kbit
			assign nbit = k_one[32-g];
		end else begin : g_zbit
			assign nbit = 1'b0;
		end

		assign trial = {rem_prev, nbit};
		assign ge    = trial >= {1'b0, den_prev};

		always_ff @(posedge clk) begin
			rem_s[g] <= ge ? RAD_W'(trial - {1'b0, den_prev}) : trial[RAD_W-1:0];
			den_s[g] <= den_prev;
			quo_s[g] <= {quo_prev[Q1_W-2:0], ge};
		end
	end

	assign quo = quo_s[DIV1_STEPS];

endmodule

// ----- design/dnrc_log.sv -----
// ----------------------------------------------------------------------------
// dnrc_log
// Natural log of quotient plus one: normalise, thirty squaring steps for the
// log2 fraction, then scale by ln 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dnrc_log import dnrc_pkg::*; (
	input  logic            clk,
	input  logic [Q1_W-1:0] quo,
	output logic [LN_W-1:0] ln
);

	logic [X_W-1:0]    nm_s [1:NORM_STEPS];
	logic [E_W-1:0]    ne_s [1:NORM_STEPS];
	logic [30:0]       sm_s [1:SQ_STEPS];
	logic [E_W-1:0]    se_s [1:SQ_STEPS];
	logic [FRAC_W-1:0] sf_s [1:SQ_STEPS];
	logic [44:0]       pa_s1;
	logic [44:0]       pb_s1;
	logic [LN_W-1:0]   ln_s2;
	logic [L2_W-1:0]   l2;
	logic [62:0]       lsum;

	// binary search for the leading one, widest shift first
	for (genvar g = 1; g <= NORM_STEPS; g++) begin : g_norm
		localparam int SH = 32 >> (g - 1);
		logic [X_W-1:0] m_prev;
		logic [E_W-1:0] e_prev;
		logic           hit;

		if (g == 1) begin : g_first
			assign m_prev = X_W'({1'b0, quo}) + ONE_Q30;
			assign e_prev = '0;
		end else begin : g_next
			assign m_prev = nm_s[g-1];
			assign e_prev = ne_s[g-1];
		end

		assign hit = (m_prev >> (30 + SH)) != '0;

		always_ff @(posedge clk) begin
			nm_s[g] <= hit ? (m_prev >> SH) : m_prev;
			ne_s[g] <= hit ? e_prev + E_W'(SH) : e_prev;
		end
	end

	// mantissa in q1.30, one fraction bit per squaring
	for (genvar g = 1; g <= SQ_STEPS; g++) begin : g_sq
		logic [30:0]       m_prev;
		logic [E_W-1:0]    e_prev;
		logic [FRAC_W-1:0] f_prev;
		logic [61:0]       sq;
		logic [31:0]       t;

		if (g == 1) begin : g_first
			assign m_prev = nm_s[NORM_STEPS][30:0];
			assign e_prev = ne_s[NORM_STEPS];
			assign f_prev = '0;
		end else begin : g_next
			assign m_prev = sm_s[g-1];
			assign e_prev = se_s[g-1];
			assign f_prev = sf_s[g-1];
		end

		assign sq = 62'(m_prev) * 62'(m_prev);
		assign t  = sq[61:30];

		always_ff @(posedge clk) begin
			sm_s[g] <= t[31] ? t[31:1] : t[30:0];
			se_s[g] <= e_prev;
			sf_s[g] <= {f_prev[FRAC_W-2:0], t[31]};
		end
	end

	assign l2 = {se_s[SQ_STEPS], sf_s[SQ_STEPS]};

	// log2 times ln 2 as two narrow partial products
	always_ff @(posedge clk) begin
		pa_s1 <= 45'(l2[L2_W-1:18]) * 45'(LN2_Q27);
		pb_s1 <= 45'(l2[17:0]) * 45'(LN2_Q27);
	end

	assign lsum = {pa_s1, 18'd0} + 63'(pb_s1);

	always_ff @(posedge clk) begin
		ln_s2 <= lsum[61:27];
	end

	assign ln = ln_s2;

endmodule
